// ===== hw/rtl/guf_pkg.sv =====
package guf_pkg;

    localparam int GRID_SIDE = 16;
    localparam int NCELLS    = GRID_SIDE * GRID_SIDE;

    localparam int CELL_W    = 8;
    localparam int DIR_W     = 2;
    localparam int DOOR_W    = 4;
    localparam int COMP_W    = 9;
    localparam int MEM_DEPTH = 2 ** CELL_W;
    localparam int COUNT_W   = $clog2(NCELLS + 1);
    localparam int PAR_W     = CELL_W + 1;

    // row = (cell * RECIP) >> RECIP_SHIFT, exact for every 8-bit cell
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'((2 ** RECIP_SHIFT + GRID_SIDE - 1) / GRID_SIDE);

    localparam logic CMD_CARVE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [DIR_W-1:0] DIR_EAST  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd1;
    localparam logic [DIR_W-1:0] DIR_WEST  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_NORTH = 2'd3;

    typedef logic [CELL_W-1:0] cell_t;

    // parent entry: top bit marks a root, low bits hold rank or link
    localparam logic [PAR_W-1:0] PAR_ROOT = {1'b1, {CELL_W{1'b0}}};

    typedef struct packed {
        logic                rd_en;
        cell_t               rd_addr;
        logic                wr_en;
        cell_t               wr_addr;
        logic [PAR_W-1:0]    wr_data;
    } par_req_t;

    typedef struct packed {
        logic                rd_en;
        cell_t               rd_addr;
        logic                wr_en;
        cell_t               wr_addr;
        logic [DOOR_W-1:0]   wr_data;
    } door_req_t;

    typedef struct packed {
        logic [DOOR_W-1:0]   doors;
        cell_t               nb;
        logic                nb_valid;
        logic                opened;
        logic                all_conn;
        logic [COMP_W-1:0]   comps;
    } result_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DECODE = 7'b0000010,
        ST_FIND_A = 7'b0000100,
        ST_FIND_B = 7'b0001000,
        ST_UNITE1 = 7'b0010000,
        ST_UNITE2 = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

endpackage

// ===== hw/rtl/guf_parent_mem.sv =====
module guf_parent_mem
    import guf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  par_req_t         req,
    output logic [PAR_W-1:0] rdata
);

    logic [PAR_W-1:0]     mem_reg [MEM_DEPTH];
    logic [PAR_W-1:0]     rd_mem_reg;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_mem_reg <= mem_reg[req.rd_addr];
        end
    end

    // entries never written read as a root of rank zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_mem_reg : PAR_ROOT;

endmodule

// ===== hw/rtl/guf_door_mem.sv =====
module guf_door_mem
    import guf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  door_req_t         req,
    output logic [DOOR_W-1:0] rdata
);

    logic [DOOR_W-1:0]    mem_reg [MEM_DEPTH];
    logic [DOOR_W-1:0]    rd_mem_reg;
    logic [MEM_DEPTH-1:0] valid_reg;
    logic                 rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_mem_reg <= mem_reg[req.rd_addr];
        end
    end

    // entries never written read as all doors closed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_mem_reg : '0;

endmodule

// ===== hw/rtl/guf_ctrl.sv =====
module guf_ctrl
    import guf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              command,
    input  cell_t             cell_req,
    input  logic [DIR_W-1:0]  direction,
    output logic              in_ready,
    input  logic              out_free,
    output logic              out_load,
    output result_t           res,
    output par_req_t          par_req,
    input  logic [PAR_W-1:0]  par_rdata,
    output door_req_t         door_req,
    input  logic [DOOR_W-1:0] door_rdata
);

    state_t               state_reg, state_next;
    logic                 cmd_reg, cmd_next;
    cell_t                cell_reg, cell_next;
    logic [DIR_W-1:0]     dir_reg, dir_next;
    cell_t                nb_reg, nb_next;
    logic                 nb_ok_reg, nb_ok_next;
    cell_t                cur_reg, cur_next;
    cell_t                ra_reg, ra_next;
    cell_t                rb_reg, rb_next;
    cell_t                rank_a_reg, rank_a_next;
    cell_t                rank_b_reg, rank_b_next;
    logic [DOOR_W-1:0]    doors_reg, doors_next;
    logic                 opened_reg, opened_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic [CELL_W+RECIP_SHIFT-1:0] row_prod;
    cell_t                row;
    cell_t                col;
    logic                 in_range;
    logic                 col_first, col_last, row_first, row_last;
    cell_t                nb_dec;
    logic                 nb_dec_ok;
    logic                 par_root;
    cell_t                par_low;
    logic [DOOR_W-1:0]    door_bit;
    logic [DOOR_W-1:0]    door_bit_opp;

    // neighbour decode from the latched cell
    always_comb
    begin
        row_prod  = cell_reg * RECIP;
        row       = row_prod[RECIP_SHIFT +: CELL_W];
        col       = cell_reg - cell_t'(row * GRID_SIDE);
        in_range  = int'(cell_reg) < NCELLS;
        col_first = (col == '0);
        col_last  = (col == cell_t'(GRID_SIDE - 1));
        row_first = int'(cell_reg) < GRID_SIDE;
        row_last  = int'(cell_reg) >= (NCELLS - GRID_SIDE);
        nb_dec    = '0;
        nb_dec_ok = 1'b0;
        unique case (dir_reg)
            DIR_EAST:
            begin
                nb_dec    = cell_reg + cell_t'(1);
                nb_dec_ok = !col_last;
            end
            DIR_SOUTH:
            begin
                nb_dec    = cell_reg + cell_t'(GRID_SIDE);
                nb_dec_ok = !row_last;
            end
            DIR_WEST:
            begin
                nb_dec    = cell_reg - cell_t'(1);
                nb_dec_ok = !col_first;
            end
            DIR_NORTH:
            begin
                nb_dec    = cell_reg - cell_t'(GRID_SIDE);
                nb_dec_ok = !row_first;
            end
            default:
            begin
                nb_dec    = '0;
                nb_dec_ok = 1'b0;
            end
        endcase
    end

    assign par_root     = par_rdata[PAR_W-1];
    assign par_low      = par_rdata[CELL_W-1:0];
    assign door_bit     = DOOR_W'(1) << dir_reg;
    assign door_bit_opp = DOOR_W'(1) << (dir_reg + DIR_W'(2));

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        cell_next   = cell_reg;
        dir_next    = dir_reg;
        nb_next     = nb_reg;
        nb_ok_next  = nb_ok_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        rank_a_next = rank_a_reg;
        rank_b_next = rank_b_reg;
        doors_next  = doors_reg;
        opened_next = opened_reg;
        count_next  = count_reg;
        in_ready    = 1'b0;
        out_load    = 1'b0;
        par_req     = '0;
        door_req    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next         = command;
                    cell_next        = cell_req;
                    dir_next         = direction;
                    door_req.rd_en   = 1'b1;
                    door_req.rd_addr = cell_req;
                    state_next       = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                opened_next = 1'b0;
                doors_next  = in_range ? door_rdata : '0;
                if (nb_dec_ok && in_range && cmd_reg == CMD_CARVE)
                begin
                    nb_next         = nb_dec;
                    nb_ok_next      = 1'b1;
                    cur_next        = cell_reg;
                    par_req.rd_en   = 1'b1;
                    par_req.rd_addr = cell_reg;
                    state_next      = ST_FIND_A;
                end
                else
                begin
                    nb_next    = '0;
                    nb_ok_next = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_FIND_A:
            begin
                par_req.rd_en = 1'b1;
                if (par_root)
                begin
                    ra_next         = cur_reg;
                    rank_a_next     = par_low;
                    par_req.rd_addr = nb_reg;
                    cur_next        = nb_reg;
                    state_next      = ST_FIND_B;
                end
                else
                begin
                    par_req.rd_addr = par_low;
                    cur_next        = par_low;
                end
            end
            ST_FIND_B:
            begin
                if (par_root)
                begin
                    rb_next     = cur_reg;
                    rank_b_next = par_low;
                    state_next  = (cur_reg == ra_reg) ? ST_OUT : ST_UNITE1;
                end
                else
                begin
                    par_req.rd_en   = 1'b1;
                    par_req.rd_addr = par_low;
                    cur_next        = par_low;
                end
            end
            ST_UNITE1:
            begin
                // door rdata still holds the named cell's doors from accept
                door_req.wr_en   = 1'b1;
                door_req.wr_addr = cell_reg;
                door_req.wr_data = door_rdata | door_bit;
                doors_next       = door_rdata | door_bit;
                door_req.rd_en   = 1'b1;
                door_req.rd_addr = nb_reg;
                par_req.wr_en    = 1'b1;
                if (rank_a_reg > rank_b_reg)
                begin
                    par_req.wr_addr = rb_reg;
                    par_req.wr_data = {1'b0, ra_reg};
                end
                else if (rank_a_reg == rank_b_reg)
                begin
                    par_req.wr_addr = rb_reg;
                    par_req.wr_data = {1'b1, rank_b_reg + cell_t'(1)};
                end
                else
                begin
                    par_req.wr_addr = ra_reg;
                    par_req.wr_data = {1'b0, rb_reg};
                end
                state_next = ST_UNITE2;
            end
            ST_UNITE2:
            begin
                door_req.wr_en   = 1'b1;
                door_req.wr_addr = nb_reg;
                door_req.wr_data = door_rdata | door_bit_opp;
                // equal ranks: second write links the cell's root below
                if (rank_a_reg == rank_b_reg)
                begin
                    par_req.wr_en   = 1'b1;
                    par_req.wr_addr = ra_reg;
                    par_req.wr_data = {1'b0, rb_reg};
                end
                if (count_reg > COUNT_W'(1))
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
                opened_next = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= COUNT_W'(NCELLS);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cell_reg   <= cell_next;
        dir_reg    <= dir_next;
        nb_reg     <= nb_next;
        nb_ok_reg  <= nb_ok_next;
        cur_reg    <= cur_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        rank_a_reg <= rank_a_next;
        rank_b_reg <= rank_b_next;
        doors_reg  <= doors_next;
        opened_reg <= opened_next;
    end

    always_comb
    begin
        res.doors    = doors_reg;
        res.nb       = nb_reg;
        res.nb_valid = nb_ok_reg;
        res.opened   = opened_reg;
        res.all_conn = (count_reg == COUNT_W'(1));
        res.comps    = COMP_W'(count_reg);
    end

endmodule

// ===== hw/rtl/grid_union_find_maze_carver.sv =====
// maze carver over a 16 x 16 grid: union-find forest plus door bits per cell
//
// input channel: command, cell_req, direction qualified by in_valid; a word is
// taken on a rising edge with in_valid high and in_stall low. one word is in
// flight at a time, in_stall is high from accept until its result is loaded.
// output channel: one result word per input word, held in an output register
// and qualified by out_valid; it is taken when out_valid is high and out_stall
// is low. while the receiver stalls the word holds and the next input word is
// still accepted and worked on; it waits once done until the register frees.
// sequence: a read, an edge hit or an out of range cell goes from accept
// through the decode state to the output state. a carve walks both parent
// chains in the parent memory, one read per cycle, and when the sets merge
// it writes the union in the unite states; union by rank keeps each depth
// at most 8. the next word is taken the cycle after a result is loaded.
// reset: every cell is its own root of rank zero, all doors are closed and
// the component count is the number of cells; valid bits per memory entry
// make this take effect at once, no clearing pass.
module grid_union_find_maze_carver
    import guf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [CELL_W-1:0] cell_req,
    input  logic [DIR_W-1:0]  direction,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DOOR_W-1:0] cell_doors,
    output logic [CELL_W-1:0] neighbour,
    output logic              neighbour_valid,
    output logic              door_opened,
    output logic              fully_linked,
    output logic [COMP_W-1:0] components
);

    par_req_t          par_req;
    door_req_t         door_req;
    logic [PAR_W-1:0]  par_rdata;
    logic [DOOR_W-1:0] door_rdata;
    logic              in_ready;
    logic              out_free;
    logic              out_load;
    result_t           res;
    result_t           out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    guf_parent_mem u_parent_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (par_req),
        .rdata (par_rdata)
    );

    guf_door_mem u_door_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (door_req),
        .rdata (door_rdata)
    );

    guf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .command    (command),
        .cell_req   (cell_req),
        .direction  (direction),
        .in_ready   (in_ready),
        .out_free   (out_free),
        .out_load   (out_load),
        .res        (res),
        .par_req    (par_req),
        .par_rdata  (par_rdata),
        .door_req   (door_req),
        .door_rdata (door_rdata)
    );

    assign in_stall = !in_ready;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_next       = out_load ? res : out_reg;
        out_valid_next = out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid       = out_valid_reg;
    assign cell_doors      = out_reg.doors;
    assign neighbour       = out_reg.nb;
    assign neighbour_valid = out_reg.nb_valid;
    assign door_opened     = out_reg.opened;
    assign fully_linked    = out_reg.all_conn;
    assign components      = out_reg.comps;

endmodule
